[rtl/assert_macros.svh]
// Assertion macros used by the line rasterizer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");

// Implication from a trigger to a consequence on the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

[rtl/lrpa_pkg.sv]
// Shared types and constants for the line rasterizer.
package lrpa_pkg;

    localparam int COORD_W = 6;
    localparam int ADDR_W  = 17;
    localparam int SCAN_W  = 11;
    localparam int REM_W   = 7;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PADDING     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_OFFSET     = 3'd4;

    // Reset values
    localparam logic [6:0]  RST_IMAGE_WIDTH  = 7'd64;
    localparam logic [6:0]  RST_IMAGE_HEIGHT = 7'd64;
    localparam logic [2:0]  RST_BPP          = 3'd3;
    localparam logic [1:0]  RST_ROW_PADDING  = 2'd0;
    localparam logic [15:0] RST_DATA_OFFSET  = 16'd54;
    localparam logic [SCAN_W-1:0] RST_SCAN   = 11'd192;

    // Line queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One classified line, walked along its major axis
    typedef struct packed {
        logic               x_major;
        logic               minor_down;
        logic [COORD_W-1:0] a0;
        logic [COORD_W-1:0] b0;
        logic [COORD_W-1:0] dmaj;
        logic [COORD_W-1:0] dmin;
    } line_desc_t;

    // Geometry settings seen by the back end
    typedef struct packed {
        logic [SCAN_W-1:0] scan;
        logic [2:0]        bpp;
        logic [6:0]        height;
        logic [15:0]       offset;
    } geom_cfg_t;

    // One emitted pixel
    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [COORD_W-1:0] top_row;
        logic [ADDR_W-1:0]  byte_address;
        logic               last_point;
    } point_t;

endpackage

[rtl/lrpa_front.sv]
// Front end: takes line endpoints and classifies them into a walk descriptor.
module lrpa_front (
    input  logic [lrpa_pkg::COORD_W-1:0] start_x,
    input  logic [lrpa_pkg::COORD_W-1:0] start_y,
    input  logic [lrpa_pkg::COORD_W-1:0] end_x,
    input  logic [lrpa_pkg::COORD_W-1:0] end_y,
    output lrpa_pkg::line_desc_t         desc
);
    import lrpa_pkg::*;

    logic [COORD_W-1:0] dx, dy;
    logic               x_major;
    logic [COORD_W-1:0] a0, b0, a1, b1;

    // absolute differences, x wins ties
    assign dx      = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
    assign dy      = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
    assign x_major = (dx >= dy);

    // order endpoints so the walk runs up the major axis
    always_comb begin
        a0 = x_major ? start_x : start_y;
        b0 = x_major ? start_y : start_x;
        a1 = x_major ? end_x   : end_y;
        b1 = x_major ? end_y   : end_x;
        if (a0 > a1) begin
            a0 = x_major ? end_x   : end_y;
            b0 = x_major ? end_y   : end_x;
            a1 = x_major ? start_x : start_y;
            b1 = x_major ? start_y : start_x;
        end
    end

    assign desc.x_major    = x_major;
    assign desc.minor_down = (b0 > b1);
    assign desc.a0         = a0;
    assign desc.b0         = b0;
    assign desc.dmaj       = x_major ? dx : dy;
    assign desc.dmin       = x_major ? dy : dx;

endmodule

[rtl/lrpa_queue.sv]
// Short queue of line descriptors between front and back.
module lrpa_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  lrpa_pkg::line_desc_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output lrpa_pkg::line_desc_t pop_data
);
    import lrpa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    line_desc_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/lrpa_back.sv]
// Back end: walks one line a pixel per cycle when not stalled and registers each pixel item.
`include "assert_macros.svh"

module lrpa_back #(
    parameter int MAX_SIDE = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lrpa_pkg::geom_cfg_t  cfg,
    input  logic                 q_not_empty,
    input  lrpa_pkg::line_desc_t q_data,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lrpa_pkg::point_t     m_point
);
    import lrpa_pkg::*;

    localparam logic [COORD_W-1:0] CAP = COORD_W'(MAX_SIDE - 1);

    line_desc_t         desc_reg;
    logic               busy_reg, busy_next;
    logic [COORD_W-1:0] step_reg, step_next;
    logic [COORD_W-1:0] shift_reg, shift_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               valid_reg, valid_next;
    point_t             point_reg;

    logic               out_free, emit, is_last, wrap;
    logic [COORD_W-1:0] major, minor, cur_x, cur_y;
    logic [REM_W-1:0]   rem_sum;
    point_t             point_now;

    // current pixel of the walk
    assign out_free = !valid_reg || m_ready;
    assign emit     = busy_reg && out_free;
    assign q_pop    = !busy_reg && q_not_empty;
    assign major    = desc_reg.a0 + step_reg;
    assign minor    = desc_reg.minor_down ? desc_reg.b0 - shift_reg
                                          : desc_reg.b0 + shift_reg;
    assign cur_x    = desc_reg.x_major ? major : minor;
    assign cur_y    = desc_reg.x_major ? minor : major;
    assign is_last  = (step_reg == desc_reg.dmaj) || (step_reg == CAP);

    // running remainder of step*dmin/dmaj, at most one carry per step
    assign rem_sum = rem_reg + {1'b0, desc_reg.dmin};
    assign wrap    = (rem_sum >= {1'b0, desc_reg.dmaj});

    // pixel fields and byte address
    always_comb begin
        point_now.point_x      = cur_x;
        point_now.point_y      = cur_y;
        point_now.top_row      = COORD_W'(cfg.height - 7'd1 - {1'b0, cur_y});
        point_now.byte_address = ADDR_W'(cfg.offset)
                               + ADDR_W'(cur_y) * ADDR_W'(cfg.scan)
                               + ADDR_W'(cur_x) * ADDR_W'(cfg.bpp);
        point_now.last_point   = is_last;
    end

    // walk control
    always_comb begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (q_pop) begin
            busy_next  = 1'b1;
            step_next  = '0;
            shift_next = '0;
            rem_next   = '0;
        end else if (emit) begin
            valid_next = 1'b1;
            busy_next  = !is_last;
            step_next  = step_reg + 1'b1;
            shift_next = shift_reg + COORD_W'(wrap);
            rem_next   = wrap ? rem_sum - {1'b0, desc_reg.dmaj} : rem_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        step_reg  <= step_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        if (q_pop) begin
            desc_reg <= q_data;
        end
        if (emit) begin
            point_reg <= point_now;
        end
    end

    assign m_valid = valid_reg;
    assign m_point = point_reg;

    `ASSERT_NEXT(a_step_advances, aclk, aresetn, emit && !is_last,
                 busy_reg && step_reg == $past(step_reg) + 1'b1)
    `ASSERT_NEXT(a_last_ends_walk, aclk, aresetn, emit && is_last, !busy_reg)
    `ASSERT_ALWAYS(a_rem_bounded, aclk, aresetn,
                   !busy_reg || desc_reg.dmaj == '0 || rem_reg < REM_W'(desc_reg.dmaj))
    `ASSERT_ALWAYS(a_shift_bounded, aclk, aresetn,
                   !busy_reg || shift_reg <= desc_reg.dmin)

endmodule

[rtl/line_rasterizer_pixel_address.sv]
// Line rasterizer top level: takes a segment, emits every pixel with its bitmap byte address.
//
// Each input item is a line segment; the block emits one result item per pixel, walking
// from the endpoint with the smaller major coordinate to the other, with tlast on the final
// pixel. A line of major difference d yields min(d+1, MAX_SIDE) pixels at one pixel per
// cycle from the back-end walker while the output is not stalled; it loads the next line
// from the two-entry queue only after it has finished the current one. The front
// end keeps accepting lines while the queue has room. Configuration writes are registered,
// the derived scan length once more, and should be made only while no line is in flight.
module line_rasterizer_pixel_address #(
    parameter int MAX_SIDE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // line input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // start_x, start_y, end_x, end_y
    // pixel output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // point_x, point_y, top_row, byte_address, zero fill
    output logic        m_tlast   // last_point
);
    import lrpa_pkg::*;

    logic [6:0]        width_reg, height_reg;
    logic [2:0]        bpp_reg;
    logic [1:0]        pad_reg;
    logic [15:0]       offset_reg;
    logic [SCAN_W-1:0] scan_reg, scan_next;

    geom_cfg_t  geom;
    line_desc_t front_desc, q_data;
    logic       q_full, q_not_empty, q_pop, push;
    point_t     point;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            bpp_reg    <= RST_BPP;
            pad_reg    <= RST_ROW_PADDING;
            offset_reg <= RST_DATA_OFFSET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IMAGE_WIDTH:     width_reg  <= cfg_wdata[6:0];
                CFG_IMAGE_HEIGHT:    height_reg <= cfg_wdata[6:0];
                CFG_BYTES_PER_PIXEL: bpp_reg    <= cfg_wdata[2:0];
                CFG_ROW_PADDING:     pad_reg    <= cfg_wdata[1:0];
                CFG_DATA_OFFSET:     offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // bytes per scan line, registered ahead of the address multiply
    assign scan_next = SCAN_W'(width_reg) * SCAN_W'(bpp_reg) + SCAN_W'(pad_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= RST_SCAN;
        end else begin
            scan_reg <= scan_next;
        end
    end

    assign geom.scan   = scan_reg;
    assign geom.bpp    = bpp_reg;
    assign geom.height = height_reg;
    assign geom.offset = offset_reg;

    // front end
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    lrpa_front u_front (
        .start_x (s_tdata[5:0]),
        .start_y (s_tdata[11:6]),
        .end_x   (s_tdata[17:12]),
        .end_y   (s_tdata[23:18]),
        .desc    (front_desc)
    );

    lrpa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    // back end
    lrpa_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (geom),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_point     (point)
    );

    assign m_tdata = {5'b0, point.byte_address, point.top_row, point.point_y, point.point_x};
    assign m_tlast = point.last_point;

endmodule
